// File: hw/rtl/mbps_pkg.sv
package mbps_pkg;

  localparam int DATA_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int ADDR_W       = 64;
  localparam int OUT_OFFSET_W = 32;
  localparam int LEN_W        = 6;
  localparam int PAT_REGS     = 4;
  localparam int PAT_BYTES    = 32;
  localparam int PAT_SEL_W    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN0  = 3'd0,
    REG_PATTERN1  = 3'd1,
    REG_PATTERN2  = 3'd2,
    REG_PATTERN3  = 3'd3,
    REG_CARE_MASK = 3'd4,
    REG_LENGTH    = 3'd5,
    REG_BASE      = 3'd6
  } cfg_reg_e;

  // Pattern setup shared by every cell of the window.
  typedef struct packed {
    logic [PAT_BYTES-1:0][DATA_W-1:0] bytes;
    logic [PAT_BYTES-1:0]             care;
    logic [LEN_W-1:0]                 length;
  } pattern_cfg_t;

endpackage

// File: hw/rtl/mbps_if.sv
interface mbps_in_if;
  logic                       valid;
  logic                       ready;
  logic [mbps_pkg::DATA_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [mbps_pkg::OUT_OFFSET_W-1:0] match_offset;
  logic [mbps_pkg::ADDR_W-1:0]       match_address;

  modport source (output valid, output found, output match_offset, output match_address,
                  input ready);
  modport sink (input valid, input found, input match_offset, input match_address,
                output ready);
endinterface

interface mbps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mbps_pkg::CFG_IDX_W-1:0]  index;
  logic [mbps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mbps_cell.sv
module mbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [mbps_pkg::DATA_W-1:0]   byte_in,
  input  mbps_pkg::pattern_cfg_t        pcfg,
  output logic [mbps_pkg::DATA_W-1:0]   byte_out,
  output logic                          hit
);
  import mbps_pkg::*;

  localparam logic [LEN_W-1:0] K = LEN_W'(CELL_IDX);

  logic [DATA_W-1:0] byte_r;
  logic [LEN_W-1:0]  pat_idx;
  logic              in_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // This cell compares the byte K places back from the newest; it lines up with
  // pattern byte length-1-K.
  assign in_use  = K < pcfg.length;
  assign pat_idx = pcfg.length - LEN_W'(1) - K;

  always_comb begin
    if (!in_use) begin
      hit = 1'b1;
    end else if (pat_idx[LEN_W-1]) begin
      // no care bit past the pattern registers: wildcard
      hit = 1'b1;
    end else if (!pcfg.care[pat_idx[PAT_SEL_W-1:0]]) begin
      hit = 1'b1;
    end else begin
      hit = byte_in == pcfg.bytes[pat_idx[PAT_SEL_W-1:0]];
    end
  end

endmodule

// File: hw/rtl/masked_byte_pattern_search_top.sv
// Masked byte pattern search.
// in_if carries one buffer byte per transaction in ascending address order;
// last_byte marks the final byte. For each buffer exactly one transaction
// leaves on out_if after the last byte is taken and registered: found, the
// offset of the first match start and base_address plus that offset (both 0
// when nothing matched). cfg_if writes the pattern, care mask, length and
// base address registers and is always ready.
// Throughput is one byte per cycle while in_if.ready is high: the window is a
// row of byte cells that shift on every byte taken below saturation, each comparing
// its byte against the pattern byte it lines up with, and the cell hits are ANDed into the match.
// The result waits in an output register; a second register behind it takes
// the next result while the first is stalled. in_if.ready goes low only while
// both hold a result, so bytes keep flowing while a single result waits.
// Reset (rst_n low, synchronous) clears the configuration, byte cells, buffer
// state and valid flags, not the result data; no clearing pass is needed. The byte
// counter saturates at all ones; bytes arriving at saturation are not searched.
module masked_byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int OFFSET_BITS       = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  mbps_in_if.sink      in_if,
  mbps_out_if.source   out_if,
  mbps_cfg_if.sink     cfg_if
);
  import mbps_pkg::*;

  localparam int CAP_W = LEN_W + 1;

  // configuration registers
  logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pattern_r;
  logic [PAT_BYTES-1:0]                care_r;
  logic [LEN_W-1:0]                    length_r;
  logic [ADDR_W-1:0]                   base_r;
  pattern_cfg_t                        pcfg;

  // buffer state
  logic [OFFSET_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic                   match_seen_r, match_seen_nxt;
  logic [OFFSET_BITS-1:0] match_off_r, match_off_nxt;

  // output stage
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic [OUT_OFFSET_W-1:0] offset_r, offset_nxt;
  logic [ADDR_W-1:0]       address_r, address_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  logic                    skid_found_r, skid_found_nxt;
  logic [OUT_OFFSET_W-1:0] skid_offset_r, skid_offset_nxt;
  logic [ADDR_W-1:0]       skid_address_r, skid_address_nxt;

  logic                          accept;
  logic                          saturated;
  logic                          shift_en;
  logic [MAX_PATTERN_BYTES-1:0]  hits;
  logic [DATA_W-1:0]             chain [MAX_PATTERN_BYTES+1];
  logic [OFFSET_BITS-1:0]        len_m1;
  logic                          len_ok;
  logic                          match_now;
  logic [OFFSET_BITS-1:0]        cand_off;
  logic                          found_any;
  logic [ADDR_W-1:0]             off_ext;
  logic                          out_free;
  logic                          res_valid;
  logic [OUT_OFFSET_W-1:0]       res_offset;
  logic [ADDR_W-1:0]             res_address;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '0;
      length_r  <= '0;
      base_r    <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_PATTERN0:  pattern_r[0] <= cfg_if.data;
        REG_PATTERN1:  pattern_r[1] <= cfg_if.data;
        REG_PATTERN2:  pattern_r[2] <= cfg_if.data;
        REG_PATTERN3:  pattern_r[3] <= cfg_if.data;
        REG_CARE_MASK: care_r       <= cfg_if.data[PAT_BYTES-1:0];
        REG_LENGTH:    length_r     <= cfg_if.data[LEN_W-1:0];
        REG_BASE:      base_r       <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign pcfg.bytes  = pattern_r;
  assign pcfg.care   = care_r;
  assign pcfg.length = length_r;

  assign in_if.ready = !skid_valid_r;
  assign accept      = in_if.valid && in_if.ready;
  assign saturated   = &bytes_seen_r;
  assign shift_en    = accept && !saturated;

  assign chain[0] = in_if.data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    mbps_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .byte_in  (chain[k]),
      .pcfg     (pcfg),
      .byte_out (chain[k+1]),
      .hit      (hits[k])
    );
  end

  assign len_m1    = OFFSET_BITS'(length_r - LEN_W'(1));
  assign len_ok    = (length_r != '0) && (CAP_W'(length_r) <= CAP_W'(MAX_PATTERN_BYTES));
  assign match_now = !saturated && !match_seen_r && len_ok &&
                     (bytes_seen_r >= len_m1) && (&hits);
  assign cand_off  = bytes_seen_r - len_m1;

  assign found_any = match_seen_r || match_now;
  assign off_ext   = ADDR_W'(match_now ? cand_off : match_off_r);

  assign res_valid   = accept && in_if.last_byte;
  assign res_offset  = found_any ? off_ext[OUT_OFFSET_W-1:0] : '0;
  assign res_address = found_any ? base_r + off_ext : '0;
  assign out_free    = !out_valid_r || out_if.ready;

  always_comb begin
    bytes_seen_nxt   = bytes_seen_r;
    match_seen_nxt   = match_seen_r;
    match_off_nxt    = match_off_r;
    out_valid_nxt    = out_valid_r && !out_if.ready;
    found_nxt        = found_r;
    offset_nxt       = offset_r;
    address_nxt      = address_r;
    skid_valid_nxt   = skid_valid_r;
    skid_found_nxt   = skid_found_r;
    skid_offset_nxt  = skid_offset_r;
    skid_address_nxt = skid_address_r;
    if (accept) begin
      if (!saturated) begin
        bytes_seen_nxt = bytes_seen_r + OFFSET_BITS'(1);
      end
      if (match_now) begin
        match_seen_nxt = 1'b1;
        match_off_nxt  = cand_off;
      end
      if (in_if.last_byte) begin
        // start a fresh buffer
        bytes_seen_nxt = '0;
        match_seen_nxt = 1'b0;
        match_off_nxt  = '0;
      end
    end
    // the skid entry is older than any new result, so it moves up first
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        found_nxt      = skid_found_r;
        offset_nxt     = skid_offset_r;
        address_nxt    = skid_address_r;
        skid_valid_nxt = 1'b0;
      end else if (res_valid) begin
        out_valid_nxt  = 1'b1;
        found_nxt      = found_any;
        offset_nxt     = res_offset;
        address_nxt    = res_address;
      end
    end else if (res_valid) begin
      skid_valid_nxt   = 1'b1;
      skid_found_nxt   = found_any;
      skid_offset_nxt  = res_offset;
      skid_address_nxt = res_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      match_seen_r <= 1'b0;
      match_off_r  <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      match_seen_r <= match_seen_nxt;
      match_off_r  <= match_off_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r        <= found_nxt;
    offset_r       <= offset_nxt;
    address_r      <= address_nxt;
    skid_found_r   <= skid_found_nxt;
    skid_offset_r  <= skid_offset_nxt;
    skid_address_r <= skid_address_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.found         = found_r;
  assign out_if.match_offset  = offset_r;
  assign out_if.match_address = address_r;

endmodule
